[design/positional_list_store_defines.svh]
// Assertion macros used by the checker file.
`ifndef POSITIONAL_LIST_STORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_DEFINES_SVH

// Check a property on every clock edge once reset is released.
`define PLS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PLS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/pls_pkg.sv]
package pls_pkg;

    // Field widths of the stream items
    localparam int DATA_W      = 32;
    localparam int KIND_W      = 3;
    localparam int POS_IN_W    = 7;
    localparam int COUNT_OUT_W = 7;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    // Capacity range and the internal position width that covers it
    localparam int MAX_CAPACITY = 1024;
    localparam int DEF_CAPACITY = 64;
    localparam int POS_W        = $clog2(MAX_CAPACITY + 1);

    // Cells OR-ed together in the first read reduction stage
    localparam int RD_GROUP = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_READ     = 3'd0,
        KIND_INS_HEAD = 3'd1,
        KIND_INS_TAIL = 3'd2,
        KIND_INS_POS  = 3'd3,
        KIND_DELETE   = 3'd4
    } kind_t;

    // Command broadcast to every cell of the row
    typedef struct packed {
        logic              ins;
        logic              del;
        logic              rd;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

[design/pls_cell.sv]
module pls_cell #(
    parameter int IDX = 0
) (
    input  logic                         clk,
    input  pls_pkg::cell_ctrl_t          ctrl,
    input  logic [pls_pkg::DATA_W-1:0]   left_data,
    input  logic [pls_pkg::DATA_W-1:0]   right_data,
    output logic [pls_pkg::DATA_W-1:0]   data,
    output logic [pls_pkg::DATA_W-1:0]   rd_data
);

    localparam logic [pls_pkg::POS_W-1:0] IDX_P = pls_pkg::POS_W'(IDX);

    logic [pls_pkg::DATA_W-1:0] data_reg;
    logic [pls_pkg::DATA_W-1:0] data_next;

    // Shift up on insert, take the new value at the slot, shift down on delete
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ins)
        begin
            if (IDX_P > ctrl.pos)
            begin
                data_next = left_data;
            end
            else if (IDX_P == ctrl.pos)
            begin
                data_next = ctrl.value;
            end
        end
        else if (ctrl.del && (IDX_P >= ctrl.pos))
        begin
            data_next = right_data;
        end
    end

    // Entry storage, no reset: entries are written before they are read
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // Drive the entry onto the read tree only when this slot is addressed
    assign rd_data = (ctrl.rd && (IDX_P == ctrl.pos)) ? data_reg : '0;
    assign data    = data_reg;

endmodule

[design/pls_read_tree.sv]
module pls_read_tree #(
    parameter int CAPACITY = pls_pkg::DEF_CAPACITY
) (
    input  logic                        clk,
    input  logic                        load,
    input  logic [pls_pkg::DATA_W-1:0]  words [CAPACITY],
    output logic [pls_pkg::DATA_W-1:0]  read_value
);

    localparam int NG = (CAPACITY + pls_pkg::RD_GROUP - 1) / pls_pkg::RD_GROUP;

    logic [pls_pkg::DATA_W-1:0] group_reg  [NG];
    logic [pls_pkg::DATA_W-1:0] group_next [NG];

    // First stage: OR each group of masked cell words
    for (genvar g = 0; g < NG; g++)
    begin : g_group
        always_comb
        begin
            group_next[g] = '0;
            for (int j = 0; j < pls_pkg::RD_GROUP; j++)
            begin
                if (g * pls_pkg::RD_GROUP + j < CAPACITY)
                begin
                    group_next[g] = group_next[g] | words[g * pls_pkg::RD_GROUP + j];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (load)
            begin
                group_reg[g] <= group_next[g];
            end
        end
    end

    // Second stage: OR the group results
    always_comb
    begin
        read_value = '0;
        for (int g = 0; g < NG; g++)
        begin
            read_value = read_value | group_reg[g];
        end
    end

endmodule

[design/positional_list_store.sv]
// Channel   Dir  Fields (tdata / tuser, lowest bit first)
// s_axis    in   tdata: position[6:0], item_value[38:7], pad[39]; tuser: kind[2:0]
// m_axis    out  tdata: read_value[31:0], ok[32], entry_count[39:33]
//
// One item per clock unless the output stalls.
// The row of cells applies insert and delete at the accept edge; a read goes
// through a two-level registered OR tree (one group stage, one output stage).
// Reset clears the entry count and all valid flags; entries are not cleared.
// A stalled output backs up one stage, then drops s_axis_tready.
module positional_list_store #(
    parameter int CAPACITY = pls_pkg::DEF_CAPACITY
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // position[6:0], item_value[38:7], zero pad[39]
    input  logic [pls_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // kind[2:0]
    input  logic [pls_pkg::KIND_W-1:0]        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // read_value[31:0], ok[32], entry_count[39:33]
    output logic [pls_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [pls_pkg::POS_W-1:0] CAP_P = pls_pkg::POS_W'(CAPACITY);

    logic                                accept;
    logic                                s1_adv;
    pls_pkg::kind_t                      kind;
    logic [pls_pkg::POS_W-1:0]           pos_ext;
    logic [pls_pkg::POS_W-1:0]           cnt_ext;
    logic [pls_pkg::POS_W-1:0]           ins_pos;
    logic                                ins_ok;
    logic                                del_ok;
    logic                                rd_ok;
    logic                                not_full;
    pls_pkg::cell_ctrl_t                 ctrl;

    logic [CW-1:0]                       count_reg;
    logic [CW-1:0]                       count_next;
    logic                                s1_valid_reg;
    logic                                s1_ok_reg;
    logic [pls_pkg::COUNT_OUT_W-1:0]     s1_count_reg;
    logic                                out_valid_reg;
    logic                                out_ok_reg;
    logic [pls_pkg::COUNT_OUT_W-1:0]     out_count_reg;
    logic [pls_pkg::DATA_W-1:0]          out_value_reg;

    logic [pls_pkg::DATA_W-1:0]          cell_data [CAPACITY];
    logic [pls_pkg::DATA_W-1:0]          rd_word   [CAPACITY];
    logic [pls_pkg::DATA_W-1:0]          tree_value;

    // Handshake: stage one moves on when the output register is free or taken
    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Decode the item against the current count
    assign kind     = pls_pkg::kind_t'(s_axis_tuser);
    assign pos_ext  = {{(pls_pkg::POS_W - pls_pkg::POS_IN_W){1'b0}},
                       s_axis_tdata[pls_pkg::POS_IN_W-1:0]};
    assign cnt_ext  = pls_pkg::POS_W'(count_reg);
    assign not_full = cnt_ext < CAP_P;

    always_comb
    begin
        ins_pos = pos_ext;
        ins_ok  = 1'b0;
        del_ok  = 1'b0;
        rd_ok   = 1'b0;
        case (kind)
            pls_pkg::KIND_READ:
            begin
                rd_ok = pos_ext < cnt_ext;
            end
            pls_pkg::KIND_INS_HEAD:
            begin
                ins_pos = '0;
                ins_ok  = not_full;
            end
            pls_pkg::KIND_INS_TAIL:
            begin
                ins_pos = cnt_ext;
                ins_ok  = not_full;
            end
            pls_pkg::KIND_INS_POS:
            begin
                ins_ok = not_full && (pos_ext <= cnt_ext);
            end
            pls_pkg::KIND_DELETE:
            begin
                del_ok = pos_ext < cnt_ext;
            end
            default:
            begin
                ins_ok = 1'b0;
            end
        endcase
    end

    // Broadcast command to the row
    always_comb
    begin
        ctrl.ins   = accept && ins_ok;
        ctrl.del   = accept && del_ok;
        ctrl.rd    = accept && rd_ok;
        ctrl.pos   = ins_pos;
        ctrl.value = s_axis_tdata[pls_pkg::POS_IN_W +: pls_pkg::DATA_W];
    end

    // Advance the entry count
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (ctrl.del)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    // Row of cells, each handing its entry to both neighbors
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [pls_pkg::DATA_W-1:0] left_w;
        logic [pls_pkg::DATA_W-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = cell_data[i+1];
        end

        pls_cell #(
            .IDX (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[i]),
            .rd_data    (rd_word[i])
        );
    end

    // Read reduction over the row
    pls_read_tree #(
        .CAPACITY (CAPACITY)
    ) u_read_tree (
        .clk        (clk),
        .load       (accept),
        .words      (rd_word),
        .read_value (tree_value)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: hold status in stage one, load the output on advance
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ok_reg    <= ins_ok || del_ok || rd_ok;
            s1_count_reg <= pls_pkg::COUNT_OUT_W'(count_next);
        end
        if (s1_adv)
        begin
            out_ok_reg    <= s1_ok_reg;
            out_count_reg <= s1_count_reg;
            out_value_reg <= tree_value;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_count_reg, out_ok_reg, out_value_reg};

endmodule

[design/pls_checker.sv]
`include "positional_list_store_defines.svh"

module pls_checker #(
    parameter int CAPACITY = pls_pkg::DEF_CAPACITY
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tready,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [pls_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    // No result is shown in the cycle after reset is seen at an edge
    `PLS_ASSERT_ALWAYS(a_no_out_in_reset, !rst_n |=> !m_axis_tvalid, "result valid during reset")

    // A stalled result keeps its payload
    `PLS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // Input back-pressure only comes from a waiting result
    `PLS_ASSERT(a_stall_cause, !s_axis_tready |-> m_axis_tvalid, "input stalled with no result waiting")

    // A nonzero read value only comes with a performed operation
    `PLS_ASSERT(a_read_ok, m_axis_tvalid && (m_axis_tdata[31:0] != '0) |-> m_axis_tdata[32], "read value without ok")

    // The reported count never exceeds capacity
    `PLS_ASSERT(a_count_cap, m_axis_tvalid |-> (CAPACITY > 127) || (m_axis_tdata[39:33] <= CAPACITY), "entry count beyond capacity")

endmodule

bind positional_list_store pls_checker #(
    .CAPACITY (CAPACITY)
) u_pls_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[dv/tb_positional_list_store.sv]
module tb_positional_list_store;

    localparam int LIST_CAP    = pls_pkg::DEF_CAPACITY;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_WAIT  = 8;

    // Kinds outside the defined operations
    localparam logic [pls_pkg::KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
    localparam logic [pls_pkg::KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

    // Result fields, highest bits first as they sit in m_axis_tdata
    typedef struct packed {
        logic [pls_pkg::COUNT_OUT_W-1:0] entry_count;
        logic                            ok;
        logic [pls_pkg::DATA_W-1:0]      read_value;
    } list_result_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [pls_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [pls_pkg::KIND_W-1:0]      s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [pls_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    // Shadow copy of the list and its count
    logic [pls_pkg::DATA_W-1:0] shadow_entries [LIST_CAP];
    int                         shadow_count = 0;

    list_result_t      pending_results [$];
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                mismatches = 0;
    int                cycles = 0;
    int                items_sent = 0;
    int                results_seen = 0;
    int                ops_done = 0;
    int                inserts_refused_full = 0;
    int                peak_count = 0;

    positional_list_store #(
        .CAPACITY(LIST_CAP)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #1 clk = ~clk;

    // Shift later entries up and place the value; refuse when full or past the end
    function automatic bit shadow_insert(int at, logic [pls_pkg::DATA_W-1:0] value);
        if (shadow_count >= LIST_CAP || at > shadow_count)
        begin
            if (shadow_count >= LIST_CAP)
                inserts_refused_full++;
            return 1'b0;
        end
        for (int i = shadow_count; i > at; i--)
            shadow_entries[i] = shadow_entries[i - 1];
        shadow_entries[at] = value;
        shadow_count++;
        return 1'b1;
    endfunction

    // Apply one list operation to the shadow copy and return its result
    function automatic list_result_t apply_list_op(logic [pls_pkg::KIND_W-1:0] kind,
                                                   logic [pls_pkg::POS_IN_W-1:0] position,
                                                   logic [pls_pkg::DATA_W-1:0] value);
        list_result_t res;
        int           at;
        res = '0;
        at  = int'(position);
        case (kind)
            pls_pkg::KIND_READ:
            begin
                if (at < shadow_count)
                begin
                    res.read_value = shadow_entries[at];
                    res.ok         = 1'b1;
                end
            end
            pls_pkg::KIND_INS_HEAD: res.ok = shadow_insert(0, value);
            pls_pkg::KIND_INS_TAIL: res.ok = shadow_insert(shadow_count, value);
            pls_pkg::KIND_INS_POS:  res.ok = shadow_insert(at, value);
            pls_pkg::KIND_DELETE:
            begin
                if (at < shadow_count)
                begin
                    for (int i = at; i + 1 < shadow_count; i++)
                        shadow_entries[i] = shadow_entries[i + 1];
                    shadow_count--;
                    res.ok = 1'b1;
                end
            end
            default: ;
        endcase
        res.entry_count = pls_pkg::COUNT_OUT_W'(shadow_count);
        return res;
    endfunction

    // Send one item, idling first at random; predict its result on accept
    task automatic send_op(logic [pls_pkg::KIND_W-1:0] kind,
                           logic [pls_pkg::POS_IN_W-1:0] position,
                           logic [pls_pkg::DATA_W-1:0] value);
        list_result_t res;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, value, position};
        s_axis_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
        res = apply_list_op(kind, position, value);
        pending_results.push_back(res);
        items_sent++;
        if (res.ok)
            ops_done++;
        if (shadow_count > peak_count)
            peak_count = shadow_count;
    endtask

    // Random stall on the result side
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Compare each result with the oldest prediction
    always @(posedge clk)
    begin : check_results
        list_result_t got;
        list_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = list_result_t'(m_axis_tdata);
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: unexpected result value=%h ok=%0d count=%0d",
                             got.read_value, got.ok, got.entry_count);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("ERROR: result %0d expected %h/%0d/%0d, got %h/%0d/%0d",
                                 results_seen, want.read_value, want.ok,
                                 want.entry_count, got.read_value, got.ok,
                                 got.entry_count);
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycles, pending_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Boundary values, empty-list cases, unknown kinds and out-of-range positions
    task automatic test_directed_edges();
        send_op(pls_pkg::KIND_READ, 7'd0, 32'h0);
        send_op(pls_pkg::KIND_DELETE, 7'd0, 32'h0);
        send_op(pls_pkg::KIND_INS_POS, 7'd1, 32'h1234_5678);
        for (int k = KIND_UNUSED_LO; k <= KIND_UNUSED_HI; k++)
            send_op(pls_pkg::KIND_W'(k), 7'd0, 32'hDEAD_BEEF);
        send_op(pls_pkg::KIND_INS_HEAD, 7'd0, 32'h8000_0000);
        send_op(pls_pkg::KIND_INS_TAIL, 7'd0, 32'h7FFF_FFFF);
        send_op(pls_pkg::KIND_INS_POS, 7'd1, 32'hFFFF_FFFF);
        send_op(pls_pkg::KIND_INS_POS, 7'd3, 32'h0000_0000);
        send_op(pls_pkg::KIND_INS_POS, 7'd5, 32'h5555_5555);
        for (int p = 0; p < 5; p++)
            send_op(pls_pkg::KIND_READ, pls_pkg::POS_IN_W'(p), 32'hAAAA_AAAA);
        send_op(pls_pkg::KIND_READ, 7'd127, 32'h0);
        send_op(pls_pkg::KIND_DELETE, 7'd64, 32'h0);
        send_op(pls_pkg::KIND_DELETE, 7'd3, 32'h0);
        send_op(pls_pkg::KIND_DELETE, 7'd0, 32'h0);
        send_op(pls_pkg::KIND_READ, 7'd1, 32'h0);
    endtask

    // Fill to capacity, hit the full-list refusal with each insert kind, then drain
    task automatic test_full_list();
        logic [pls_pkg::KIND_W-1:0] kind;
        while (shadow_count < LIST_CAP)
        begin
            case ($urandom_range(0, 2))
                0:       kind = pls_pkg::KIND_INS_HEAD;
                1:       kind = pls_pkg::KIND_INS_TAIL;
                default: kind = pls_pkg::KIND_INS_POS;
            endcase
            send_op(kind, pls_pkg::POS_IN_W'($urandom_range(0, shadow_count)), $urandom);
        end
        for (int r = 0; r < 2; r++)
        begin
            send_op(pls_pkg::KIND_INS_HEAD, 7'd0, $urandom);
            send_op(pls_pkg::KIND_INS_TAIL, 7'd0, $urandom);
            send_op(pls_pkg::KIND_INS_POS, pls_pkg::POS_IN_W'($urandom_range(0, LIST_CAP)),
                    $urandom);
        end
        send_op(pls_pkg::KIND_READ, 7'd0, 32'h0);
        send_op(pls_pkg::KIND_READ, pls_pkg::POS_IN_W'(LIST_CAP - 1), 32'h0);
        send_op(pls_pkg::KIND_READ, pls_pkg::POS_IN_W'(LIST_CAP), 32'h0);
        while (shadow_count > 0)
        begin
            send_op(pls_pkg::KIND_DELETE,
                    pls_pkg::POS_IN_W'($urandom_range(0, shadow_count - 1)), $urandom);
            if ($urandom_range(0, 3) == 0)
                send_op(pls_pkg::KIND_READ,
                        pls_pkg::POS_IN_W'($urandom_range(0, shadow_count)), $urandom);
        end
    endtask

    // Mixed operations, drifting between growing and shrinking the list
    task automatic test_random_ops(int n_items);
        logic [pls_pkg::KIND_W-1:0]   kind;
        logic [pls_pkg::POS_IN_W-1:0] position;
        bit                           growing;
        int                           roll;
        growing = 1'b1;
        for (int n = 0; n < n_items; n++)
        begin
            if (shadow_count == LIST_CAP || $urandom_range(0, 99) < 3)
                growing = 1'b0;
            if (shadow_count == 0)
                growing = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 5)
                kind = pls_pkg::KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
            else if (roll < 30)
                kind = pls_pkg::KIND_READ;
            else if (roll < (growing ? 85 : 45))
                case ($urandom_range(0, 2))
                    0:       kind = pls_pkg::KIND_INS_HEAD;
                    1:       kind = pls_pkg::KIND_INS_TAIL;
                    default: kind = pls_pkg::KIND_INS_POS;
                endcase
            else
                kind = pls_pkg::KIND_DELETE;
            if ($urandom_range(0, 4) == 0)
                position = pls_pkg::POS_IN_W'($urandom_range(0, 127));
            else
                position = pls_pkg::POS_IN_W'($urandom_range(0, shadow_count));
            send_op(kind, position, $urandom);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 24;
        recv_idle_pct = 67;
        test_directed_edges();
        test_random_ops(110);

        send_idle_pct = 67;
        recv_idle_pct = 24;
        test_full_list();
        test_random_ops(60);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_ops(150);

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d operations (%0d performed), %0d results checked, %0d mismatches",
                 items_sent, ops_done, results_seen, mismatches);
        $display("List reached %0d of %0d entries; %0d inserts refused on a full list",
                 peak_count, LIST_CAP, inserts_refused_full);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[positional_list_store.f]
+incdir+design
design/pls_pkg.sv
design/pls_cell.sv
design/pls_read_tree.sv
design/positional_list_store.sv
design/pls_checker.sv
dv/tb_positional_list_store.sv
